@@ rtl/core/kotp_pkg.sv @@
// shared constants, codes and types of the keyed one-shot timer pool
package kotp_pkg;

   // pool size and slot index width
   localparam int SLOTS = 16;
   localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // field widths
   localparam int KEY_W  = 32;
   localparam int ID_W   = 16;
   localparam int TAG_W  = 32;
   localparam int MS_W   = 32;
   localparam int RATE_W = 10;
   localparam int TICK_W = 32;

   localparam logic [RATE_W-1:0] RATE_RESET = 10'd100;

   // delay conversion: ms times rate, then divide by 1000 as a shift by 3 and a
   // product with the rounded-up reciprocal of 125 (exact for products below 2^42),
   // taken one 13-bit chunk of the shifted product a cycle, top chunk first
   localparam int DLY_PROD_W  = MS_W + RATE_W;
   localparam int RCP_IN_W    = DLY_PROD_W - 3;
   localparam int RCP_W       = 40;
   localparam int RCP_SHIFT   = 46;
   localparam logic [RCP_W-1:0] RCP_CONST = 40'd562949953422;
   localparam int RCP_CHUNK_W = 13;
   localparam int RCP_CHUNKS  = RCP_IN_W / RCP_CHUNK_W;
   localparam int RCP_CNT_W   = $clog2(RCP_CHUNKS);
   localparam int RCP_PART_W  = RCP_W + RCP_CHUNK_W;
   localparam int RCP_ACC_W   = RCP_IN_W + RCP_W;
   localparam int QUOT_W      = RCP_ACC_W - RCP_SHIFT;

   // request opcodes
   typedef enum logic [1:0] {
      OP_SET     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CHECK   = 2'd2,
      OP_TICK    = 2'd3
   } kotp_op_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_SET_REPLY   = 2'd0,
      KIND_RELEASE_ACK = 2'd1,
      KIND_CHECK_REPLY = 2'd2,
      KIND_EXPIRY      = 2'd3
   } kotp_kind_type;

   // controller states
   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_SCAN,
      CTL_WAIT,
      CTL_WRITE,
      CTL_DONE
   } kotp_ctl_state_type;

   // delay converter states
   typedef enum logic [1:0] {
      DLY_IDLE,
      DLY_MUL,
      DLY_SAT
   } kotp_dly_state_type;

   // contents of one slot as it moves along the ring
   typedef struct packed {
      logic [KEY_W-1:0]  handler;
      logic [ID_W-1:0]   id;
      logic [TAG_W-1:0]  tag;
      logic [TICK_W-1:0] remaining;
      logic              allocated;
      logic              running;
   } kotp_slot_type;

   // command broadcast to the cells
   typedef struct packed {
      logic              apply;
      kotp_op_type       op;
      logic [KEY_W-1:0]  key;
      logic [ID_W-1:0]   id;
      logic [TAG_W-1:0]  tag;
      logic [TICK_W-1:0] ticks;
   } kotp_cmd_type;

   // status a cell reports on what it holds
   typedef struct packed {
      logic             match;
      logic             free;
      logic             running;
      logic             fire;
      logic [KEY_W-1:0] handler;
      logic [ID_W-1:0]  id;
      logic [TAG_W-1:0] tag;
   } kotp_stat_type;

endpackage

@@ rtl/core/kotp_cell.sv @@
// one slot cell of the rotating ring: holds a slot, reports on it, updates it on the way out
module kotp_cell import kotp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          shift_en,
   input  kotp_slot_type slot_in,
   input  kotp_cmd_type  cmd,
   output kotp_slot_type slot_out,
   output kotp_stat_type stat
);

   logic [KEY_W-1:0]  handler_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [TICK_W-1:0] remaining_ff;
   logic              allocated_ff;
   logic              running_ff;
   logic              expiring;

   // status of the held slot
   assign expiring     = running_ff && (remaining_ff <= TICK_W'(1));
   assign stat.match   = allocated_ff && (handler_ff == cmd.key) && (id_ff == cmd.id);
   assign stat.free    = !allocated_ff;
   assign stat.running = running_ff;
   assign stat.fire    = expiring && allocated_ff && (handler_ff != '0);
   assign stat.handler = handler_ff;
   assign stat.id      = id_ff;
   assign stat.tag     = tag_ff;

   // updated slot handed to the neighbor
   always_comb begin
      slot_out.handler   = handler_ff;
      slot_out.id        = id_ff;
      slot_out.tag       = tag_ff;
      slot_out.remaining = remaining_ff;
      slot_out.allocated = allocated_ff;
      slot_out.running   = running_ff;
      if (cmd.apply) begin
         unique case (cmd.op)
            OP_SET: begin
               slot_out.handler   = cmd.key;
               slot_out.id        = cmd.id;
               slot_out.tag       = cmd.tag;
               slot_out.remaining = cmd.ticks;
               slot_out.allocated = 1'b1;
               slot_out.running   = 1'b1;
            end
            OP_RELEASE: begin
               if (stat.match) begin
                  slot_out.allocated = 1'b0;
                  slot_out.running   = 1'b0;
               end
            end
            OP_TICK: begin
               if (expiring) begin
                  slot_out.remaining = '0;
                  slot_out.running   = 1'b0;
               end else if (running_ff) begin
                  slot_out.remaining = remaining_ff - TICK_W'(1);
               end
            end
            OP_CHECK: begin
            end
         endcase
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      if (shift_en) begin
         handler_ff   <= slot_in.handler;
         id_ff        <= slot_in.id;
         tag_ff       <= slot_in.tag;
         remaining_ff <= slot_in.remaining;
      end
   end

   // slot flags
   always_ff @(posedge clock) begin
      if (reset) begin
         allocated_ff <= 1'b0;
         running_ff   <= 1'b0;
      end else if (shift_en) begin
         allocated_ff <= slot_in.allocated;
         running_ff   <= slot_in.running;
      end
   end

endmodule

@@ rtl/core/kotp_delay.sv @@
// delay converter: ms times tick rate, divided by 1000 through a reciprocal product, then clamped
module kotp_delay import kotp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MS_W-1:0]   delay_ms,
   input  logic [RATE_W-1:0] tick_rate,
   output logic              idle,
   output logic [TICK_W-1:0] ticks
);

   localparam logic [RCP_CNT_W-1:0] CNT_LAST = RCP_CNT_W'(RCP_CHUNKS - 1);

   kotp_dly_state_type      state_ff, state_in;
   logic [RCP_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [RCP_IN_W-1:0]     src_ff, src_in;
   logic [RCP_ACC_W-1:0]    acc_ff, acc_in;
   logic [TICK_W-1:0]       ticks_ff, ticks_in;
   logic [DLY_PROD_W-1:0]   product;
   logic [RCP_PART_W-1:0]   part;
   logic [QUOT_W-1:0]       quot;

   assign idle  = (state_ff == DLY_IDLE);
   assign ticks = ticks_ff;

   // ms times rate, top chunk times the reciprocal, quotient from the top of the sum
   assign product = DLY_PROD_W'(delay_ms) * DLY_PROD_W'(tick_rate);
   assign part    = RCP_PART_W'(RCP_CONST) *
                    RCP_PART_W'(src_ff[RCP_IN_W-1 -: RCP_CHUNK_W]);
   assign quot    = acc_ff[RCP_ACC_W-1:RCP_SHIFT];

   // next state: load product, accumulate chunk products, saturation
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      src_in   = src_ff;
      acc_in   = acc_ff;
      ticks_in = ticks_ff;
      unique case (state_ff)
         DLY_IDLE: begin
            if (start) begin
               src_in   = product[DLY_PROD_W-1:DLY_PROD_W-RCP_IN_W];
               acc_in   = '0;
               cnt_in   = '0;
               state_in = DLY_MUL;
            end
         end
         DLY_MUL: begin
            acc_in = {acc_ff[RCP_ACC_W-RCP_CHUNK_W-1:0], {RCP_CHUNK_W{1'b0}}} +
                     RCP_ACC_W'(part);
            src_in = {src_ff[RCP_IN_W-RCP_CHUNK_W-1:0], {RCP_CHUNK_W{1'b0}}};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = DLY_SAT;
            end
         end
         DLY_SAT: begin
            if (quot[QUOT_W-1:TICK_W] != '0) begin
               ticks_in = '1;
            end else if (quot[TICK_W-1:0] == '0) begin
               ticks_in = TICK_W'(1);
            end else begin
               ticks_in = quot[TICK_W-1:0];
            end
            state_in = DLY_IDLE;
         end
         default: begin
            state_in = DLY_IDLE;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DLY_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      src_ff   <= src_in;
      acc_ff   <= acc_in;
      ticks_ff <= ticks_in;
   end

endmodule

@@ rtl/core/keyed_oneshot_timer_pool.sv @@
// top level: ring of slot cells, delay converter and request controller
//
// Usage
//   Requests are commands: drive req_* with start high; the transfer happens
//   at a clock edge where busy is low. busy stays high until the request has
//   finished. Results come out on rsp_* for exactly one cycle, marked by
//   rsp_valid; the receiver must take them, it cannot stall the block.
//   Set, release and check give one result each. A tick gives one expiry
//   event per slot that runs out, in ascending slot order, with rsp_last on
//   the final one, and nothing when no slot runs out.
//   The slots sit in a ring of SLOTS cells that rotates one place a cycle
//   while the controller scans or writes; every request starts with one
//   full turn past the head cell. Release, check and tick: that turn, then
//   the closing state. Set: a search turn, a wait until the delay converter
//   is idle, a write turn, then the closing state; a null key or no slot
//   to use skips wait and write. The conversion ends inside the search turn.
//   csr_wr_data sets the tick rate; write it only while busy is low.
//   Reset (synchronous) frees every slot and sets the tick rate to 100.
module keyed_oneshot_timer_pool import kotp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [KEY_W-1:0]  req_handler_key,
   input  logic [ID_W-1:0]   req_timer_id,
   input  logic [TAG_W-1:0]  req_message_tag,
   input  logic [MS_W-1:0]   req_delay_ms,
   output logic              rsp_valid,
   output logic [1:0]        rsp_kind,
   output logic              rsp_ok,
   output logic [KEY_W-1:0]  rsp_event_handler,
   output logic [ID_W-1:0]   rsp_event_id,
   output logic [TAG_W-1:0]  rsp_event_tag,
   output logic              rsp_last,
   input  logic              csr_wr_en,
   input  logic [RATE_W-1:0] csr_wr_data
);

   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SLOTS - 1);

   kotp_ctl_state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   kotp_op_type        op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic               match_found_ff, match_found_in;
   logic [CNT_W-1:0]   match_idx_ff, match_idx_in;
   logic               free_found_ff, free_found_in;
   logic [CNT_W-1:0]   free_idx_ff, free_idx_in;
   logic               hit_ff, hit_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [KEY_W-1:0]   pend_handler_ff, pend_handler_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in;
   logic [TAG_W-1:0]   pend_tag_ff, pend_tag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kotp_kind_type      rsp_kind_ff, rsp_kind_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [KEY_W-1:0]   rsp_handler_ff, rsp_handler_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [RATE_W-1:0]  tick_rate_ff;

   logic               shift_en;
   kotp_cmd_type       head_cmd;
   kotp_slot_type      cell_out [SLOTS];
   kotp_stat_type      cell_stat [SLOTS];
   kotp_stat_type      head_stat;
   logic [CNT_W-1:0]   target;
   logic               dly_start;
   logic               dly_idle;
   logic [TICK_W-1:0]  dly_ticks;

   assign busy              = (state_ff != CTL_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_event_handler = rsp_handler_ff;
   assign rsp_event_id      = rsp_id_ff;
   assign rsp_event_tag     = rsp_tag_ff;
   assign rsp_last          = rsp_last_ff;
   assign head_stat         = cell_stat[0];
   assign target            = match_found_ff ? match_idx_ff : free_idx_ff;
   assign dly_start         = start && !busy && (kotp_op_type'(req_opcode) == OP_SET);

   // tick rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= RATE_RESET;
      end else if (csr_wr_en) begin
         tick_rate_ff <= csr_wr_data;
      end
   end

   // delay conversion for set requests
   kotp_delay u_delay (
      .clock     (clock),
      .reset     (reset),
      .start     (dly_start),
      .delay_ms  (req_delay_ms),
      .tick_rate (tick_rate_ff),
      .idle      (dly_idle),
      .ticks     (dly_ticks)
   );

   // ring of slot cells; only the head cell acts on the command
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      localparam int NEXT = (i + 1) % SLOTS;
      kotp_cmd_type cell_cmd;
      if (i == 0) begin : g_head
         assign cell_cmd = head_cmd;
      end else begin : g_body
         always_comb begin
            cell_cmd       = head_cmd;
            cell_cmd.apply = 1'b0;
         end
      end
      kotp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .slot_in  (cell_out[NEXT]),
         .cmd      (cell_cmd),
         .slot_out (cell_out[i]),
         .stat     (cell_stat[i])
      );
   end

   // controller next state and outputs
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      id_in           = id_ff;
      tag_in          = tag_ff;
      match_found_in  = match_found_ff;
      match_idx_in    = match_idx_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      hit_in          = hit_ff;
      pend_valid_in   = pend_valid_ff;
      pend_handler_in = pend_handler_ff;
      pend_id_in      = pend_id_ff;
      pend_tag_in     = pend_tag_ff;
      rsp_valid_in    = 1'b0;
      rsp_kind_in     = rsp_kind_ff;
      rsp_ok_in       = rsp_ok_ff;
      rsp_handler_in  = rsp_handler_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_tag_in      = rsp_tag_ff;
      rsp_last_in     = rsp_last_ff;
      shift_en        = 1'b0;
      head_cmd.apply  = 1'b0;
      head_cmd.op     = op_ff;
      head_cmd.key    = key_ff;
      head_cmd.id     = id_ff;
      head_cmd.tag    = tag_ff;
      head_cmd.ticks  = dly_ticks;
      unique case (state_ff)
         CTL_IDLE: begin
            if (start) begin
               op_in          = kotp_op_type'(req_opcode);
               key_in         = req_handler_key;
               id_in          = req_timer_id;
               tag_in         = req_message_tag;
               cnt_in         = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               hit_in         = 1'b0;
               pend_valid_in  = 1'b0;
               state_in       = CTL_SCAN;
            end
         end
         CTL_SCAN: begin
            shift_en = 1'b1;
            unique case (op_ff)
               OP_SET: begin
                  if (head_stat.match && !match_found_ff) begin
                     match_found_in = 1'b1;
                     match_idx_in   = cnt_ff;
                  end
                  if (head_stat.free && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = cnt_ff;
                  end
               end
               OP_RELEASE: begin
                  head_cmd.apply = (key_ff != '0);
               end
               OP_CHECK: begin
                  if ((key_ff != '0) && head_stat.match && head_stat.running) begin
                     hit_in = 1'b1;
                  end
               end
               OP_TICK: begin
                  head_cmd.apply = 1'b1;
                  // hold each event back one find so the final one gets last
                  if (head_stat.fire) begin
                     if (pend_valid_ff) begin
                        rsp_valid_in   = 1'b1;
                        rsp_kind_in    = KIND_EXPIRY;
                        rsp_ok_in      = 1'b0;
                        rsp_handler_in = pend_handler_ff;
                        rsp_id_in      = pend_id_ff;
                        rsp_tag_in     = pend_tag_ff;
                        rsp_last_in    = 1'b0;
                     end
                     pend_valid_in   = 1'b1;
                     pend_handler_in = head_stat.handler;
                     pend_id_in      = head_stat.id;
                     pend_tag_in     = head_stat.tag;
                  end
               end
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in = '0;
               if ((op_ff == OP_SET) && (key_ff != '0) && (match_found_in || free_found_in)) begin
                  state_in = CTL_WAIT;
               end else begin
                  state_in = CTL_DONE;
               end
            end
         end
         CTL_WAIT: begin
            if (dly_idle) begin
               state_in = CTL_WRITE;
            end
         end
         CTL_WRITE: begin
            shift_en       = 1'b1;
            head_cmd.apply = (cnt_ff == target);
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = CTL_DONE;
            end
         end
         CTL_DONE: begin
            rsp_valid_in   = 1'b1;
            rsp_ok_in      = 1'b0;
            rsp_handler_in = '0;
            rsp_id_in      = '0;
            rsp_tag_in     = '0;
            rsp_last_in    = 1'b1;
            unique case (op_ff)
               OP_SET: begin
                  rsp_kind_in = KIND_SET_REPLY;
                  rsp_ok_in   = (key_ff != '0) && (match_found_ff || free_found_ff);
               end
               OP_RELEASE: begin
                  rsp_kind_in = KIND_RELEASE_ACK;
               end
               OP_CHECK: begin
                  rsp_kind_in = KIND_CHECK_REPLY;
                  rsp_ok_in   = hit_ff;
               end
               OP_TICK: begin
                  rsp_valid_in   = pend_valid_ff;
                  rsp_kind_in    = KIND_EXPIRY;
                  rsp_handler_in = pend_handler_ff;
                  rsp_id_in      = pend_id_ff;
                  rsp_tag_in     = pend_tag_ff;
               end
            endcase
            pend_valid_in = 1'b0;
            state_in      = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   // controller state and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CTL_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // request, search and result payload
   always_ff @(posedge clock) begin
      cnt_ff          <= cnt_in;
      op_ff           <= op_in;
      key_ff          <= key_in;
      id_ff           <= id_in;
      tag_ff          <= tag_in;
      match_found_ff  <= match_found_in;
      match_idx_ff    <= match_idx_in;
      free_found_ff   <= free_found_in;
      free_idx_ff     <= free_idx_in;
      hit_ff          <= hit_in;
      pend_handler_ff <= pend_handler_in;
      pend_id_ff      <= pend_id_in;
      pend_tag_ff     <= pend_tag_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_ok_ff       <= rsp_ok_in;
      rsp_handler_ff  <= rsp_handler_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_tag_ff      <= rsp_tag_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // a result only follows a scan step or the closing state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == CTL_SCAN || state_ff == CTL_DONE))
      else $error("result strobe outside scan or close");

   // an accepted request starts a ring turn
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == CTL_SCAN))
      else $error("accepted request did not start a scan");

   // the write turn needs a converted delay and a chosen slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_WRITE) |-> (dly_idle && (match_found_ff || free_found_ff)))
      else $error("write turn without delay or target slot");

   // only expiry events can be followed by more results
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff != KIND_EXPIRY)) |-> rsp_last_ff)
      else $error("request reply not marked last");

   // a held-back event exists only during a tick
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (op_ff == OP_TICK))
      else $error("pending expiry outside a tick");

endmodule

@@ verif/keyed_oneshot_timer_pool_tb.sv @@
// self-checking testbench for the keyed one-shot timer pool
module keyed_oneshot_timer_pool_tb import kotp_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_PAIRS   = 20;
   localparam int DRAIN_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES = 6;

   typedef struct packed {
      kotp_op_type       op;
      logic [KEY_W-1:0]  key;
      logic [ID_W-1:0]   id;
      logic [TAG_W-1:0]  tag;
      logic [MS_W-1:0]   delay_ms;
   } timer_req_type;

   typedef struct packed {
      kotp_kind_type     kind;
      logic              ok;
      logic [KEY_W-1:0]  handler;
      logic [ID_W-1:0]   id;
      logic [TAG_W-1:0]  tag;
      logic              last;
   } timer_rsp_type;

   // block ports
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_opcode = '0;
   logic [KEY_W-1:0]  req_handler_key = '0;
   logic [ID_W-1:0]   req_timer_id = '0;
   logic [TAG_W-1:0]  req_message_tag = '0;
   logic [MS_W-1:0]   req_delay_ms = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_kind;
   logic              rsp_ok;
   logic [KEY_W-1:0]  rsp_event_handler;
   logic [ID_W-1:0]   rsp_event_id;
   logic [TAG_W-1:0]  rsp_event_tag;
   logic              rsp_last;
   logic              csr_wr_en = 1'b0;
   logic [RATE_W-1:0] csr_wr_data = '0;

   // predicted pool contents and tick rate
   logic [KEY_W-1:0]  pool_handler [SLOTS];
   logic [ID_W-1:0]   pool_id [SLOTS];
   logic [TAG_W-1:0]  pool_tag [SLOTS];
   logic [TICK_W-1:0] pool_remaining [SLOTS];
   logic              pool_allocated [SLOTS];
   logic              pool_running [SLOTS];
   logic [RATE_W-1:0] tick_rate = RATE_RESET;

   // keys the random requests draw from; entry 0 is the null handler
   logic [KEY_W-1:0]  pair_handler [KEY_PAIRS];
   logic [ID_W-1:0]   pair_id [KEY_PAIRS];

   timer_req_type pending_requests [$];
   timer_rsp_type expected_results [$];
   timer_req_type active_request;
   timer_rsp_type oldest_expected;
   logic          request_held;
   int            sender_idle_pct = 0;
   int            mismatch_count = 0;

   keyed_oneshot_timer_pool u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_handler_key   (req_handler_key),
      .req_timer_id      (req_timer_id),
      .req_message_tag   (req_message_tag),
      .req_delay_ms      (req_delay_ms),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_ok            (rsp_ok),
      .rsp_event_handler (rsp_event_handler),
      .rsp_event_id      (rsp_event_id),
      .rsp_event_tag     (rsp_event_tag),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("keyed_oneshot_timer_pool_tb NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 100) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
      end
   endtask

   // delay in ms to ticks, minimum one tick, saturating at the counter width
   function automatic logic [TICK_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
      logic [63:0] quotient;
      quotient = (64'(ms) * 64'(tick_rate)) / 64'd1000;
      if (quotient == 64'd0) return TICK_W'(1);
      if (quotient > 64'h0000_0000_FFFF_FFFF) return '1;
      return quotient[TICK_W-1:0];
   endfunction

   function automatic int find_pool_slot(input logic [KEY_W-1:0] key,
                                         input logic [ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++) begin
         if (pool_allocated[i] && pool_handler[i] == key && pool_id[i] == id) return i;
      end
      return -1;
   endfunction

   // update the predicted pool for one accepted request, queue its results
   task automatic apply_timer_request(input timer_req_type r);
      int            slot;
      logic          held;
      timer_rsp_type res;
      timer_rsp_type event_hold;
      slot = -1;
      held = 1'b0;
      res = '0;
      event_hold = '0;
      case (r.op)
         OP_SET: begin
            res.kind = KIND_SET_REPLY;
            if (r.key != '0) begin
               slot = find_pool_slot(r.key, r.id);
               if (slot < 0) begin
                  for (int i = SLOTS - 1; i >= 0; i--) begin
                     if (!pool_allocated[i]) slot = i;
                  end
                  if (slot >= 0) begin
                     pool_handler[slot] = r.key;
                     pool_id[slot] = r.id;
                     pool_allocated[slot] = 1'b1;
                  end
               end
               if (slot >= 0) begin
                  pool_tag[slot] = r.tag;
                  pool_remaining[slot] = ms_to_ticks(r.delay_ms);
                  pool_running[slot] = 1'b1;
                  res.ok = 1'b1;
               end
            end
            res.last = 1'b1;
            expected_results.push_back(res);
         end
         OP_RELEASE: begin
            res.kind = KIND_RELEASE_ACK;
            if (r.key != '0) begin
               slot = find_pool_slot(r.key, r.id);
               if (slot >= 0) begin
                  pool_running[slot] = 1'b0;
                  pool_allocated[slot] = 1'b0;
               end
            end
            res.last = 1'b1;
            expected_results.push_back(res);
         end
         OP_CHECK: begin
            res.kind = KIND_CHECK_REPLY;
            if (r.key != '0) begin
               slot = find_pool_slot(r.key, r.id);
               if (slot >= 0 && pool_running[slot]) res.ok = 1'b1;
            end
            res.last = 1'b1;
            expected_results.push_back(res);
         end
         default: begin
            // one tick: expiries in ascending slot order, last flag on the final one
            for (int i = 0; i < SLOTS; i++) begin
               if (pool_running[i]) begin
                  if (pool_remaining[i] <= TICK_W'(1)) begin
                     pool_remaining[i] = '0;
                     pool_running[i] = 1'b0;
                     if (pool_allocated[i] && pool_handler[i] != '0) begin
                        if (held) expected_results.push_back(event_hold);
                        event_hold = '0;
                        event_hold.kind = KIND_EXPIRY;
                        event_hold.handler = pool_handler[i];
                        event_hold.id = pool_id[i];
                        event_hold.tag = pool_tag[i];
                        held = 1'b1;
                     end
                  end else begin
                     pool_remaining[i] = pool_remaining[i] - TICK_W'(1);
                  end
               end
            end
            if (held) begin
               event_hold.last = 1'b1;
               expected_results.push_back(event_hold);
            end
         end
      endcase
   endtask

   task automatic push_request(input kotp_op_type op, input int pair,
                               input logic [TAG_W-1:0] tag, input logic [MS_W-1:0] ms);
      timer_req_type r;
      r.op = op;
      r.key = pair_handler[pair];
      r.id = pair_id[pair];
      r.tag = tag;
      r.delay_ms = ms;
      pending_requests.push_back(r);
   endtask

   // mostly requests on a small key set so slots match, fill up and expire
   function automatic timer_req_type random_request();
      timer_req_type r;
      int pick;
      int pair;
      int span;
      pick = $urandom_range(0, 99);
      pair = $urandom_range(0, KEY_PAIRS - 1);
      r.key = pair_handler[pair];
      r.id = pair_id[pair];
      r.tag = $urandom;
      r.delay_ms = $urandom;
      if (pick < 5) begin
         // noise: any opcode on an arbitrary key
         r.op = kotp_op_type'($urandom_range(0, 3));
         r.key = $urandom;
         r.id = ID_W'($urandom);
      end else if (pick < 40) begin
         r.op = OP_SET;
         span = (tick_rate == '0) ? 1000 : 8000 / int'(tick_rate);
         case ($urandom_range(0, 19))
            0: r.delay_ms = $urandom;
            1: r.delay_ms = '1;
            2: r.delay_ms = '0;
            default: r.delay_ms = $urandom_range(0, span);
         endcase
      end else if (pick < 55) begin
         r.op = OP_RELEASE;
      end else if (pick < 70) begin
         r.op = OP_CHECK;
      end else begin
         r.op = OP_TICK;
      end
      return r;
   endfunction

   // wait for the driver to empty, every result to arrive and the block to go idle
   task automatic settle_pool();
      int waited;
      waited = 0;
      while (pending_requests.size() != 0 || start) @(negedge clock);
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (expected_results.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never came",
                                   expected_results.size()));
         expected_results.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_tick_rate(input logic [RATE_W-1:0] rate);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= rate;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tick_rate = rate;
   endtask

   // request driver: holds start until the transfer, then maybe idles
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         request_held = start;
         if (start && !busy) begin
            apply_timer_request(active_request);
            request_held = 1'b0;
         end
         if (!request_held) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               active_request = pending_requests.pop_front();
               start <= 1'b1;
               req_opcode <= active_request.op;
               req_handler_key <= active_request.key;
               req_timer_id <= active_request.id;
               req_message_tag <= active_request.tag;
               req_delay_ms <= active_request.delay_ms;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // result monitor: every strobed result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d", rsp_kind));
         end else begin
            oldest_expected = expected_results.pop_front();
            check_field("kind", 32'(rsp_kind), 32'(oldest_expected.kind));
            check_field("ok", 32'(rsp_ok), 32'(oldest_expected.ok));
            check_field("event_handler", rsp_event_handler, oldest_expected.handler);
            check_field("event_id", 32'(rsp_event_id), 32'(oldest_expected.id));
            check_field("event_tag", rsp_event_tag, oldest_expected.tag);
            check_field("last", 32'(rsp_last), 32'(oldest_expected.last));
         end
      end
   end

   // stimulus
   initial begin
      int phase_rate [PHASES];
      int phase_idle [PHASES];
      int phase_items [PHASES];
      phase_rate = '{1000, 1, 0, 1023, 0, 100};
      phase_idle = '{65, 0, 33, 65, 33, 0};
      phase_items = '{50, 40, 30, 40, 50, 40};
      phase_rate[4] = $urandom_range(2, 999);

      for (int i = 0; i < SLOTS; i++) begin
         pool_handler[i] = '0;
         pool_id[i] = '0;
         pool_tag[i] = '0;
         pool_remaining[i] = '0;
         pool_allocated[i] = 1'b0;
         pool_running[i] = 1'b0;
      end

      // key set: null, all ones, shared handler and shared id pairs, then random
      pair_handler[0] = '0;
      pair_id[0] = ID_W'($urandom);
      pair_handler[1] = '1;
      pair_id[1] = '1;
      pair_handler[2] = 32'd1;
      pair_id[2] = '0;
      pair_handler[3] = 32'd1;
      pair_id[3] = 16'd1;
      pair_handler[4] = 32'h8000_0000;
      pair_id[4] = '0;
      for (int i = 5; i < KEY_PAIRS; i++) begin
         pair_handler[i] = $urandom;
         if (pair_handler[i] == '0) pair_handler[i] = 32'd2;
         pair_id[i] = ID_W'($urandom);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: null handler, no-match release, expiry, restart, pool full
      push_request(OP_SET, 0, '1, 32'd5);
      push_request(OP_CHECK, 0, '0, '0);
      push_request(OP_RELEASE, 0, '0, '0);
      push_request(OP_RELEASE, 1, '0, '0);
      push_request(OP_SET, 1, '0, '0);
      push_request(OP_CHECK, 1, '0, '0);
      push_request(OP_TICK, 0, $urandom, $urandom);
      push_request(OP_CHECK, 1, '0, '0);
      push_request(OP_SET, 1, '1, 32'd20);
      for (int i = 2; i <= SLOTS; i++) begin
         push_request(OP_SET, i, $urandom, '1);
      end
      push_request(OP_SET, SLOTS + 1, $urandom, 32'd10);
      push_request(OP_RELEASE, 1, '0, '0);
      push_request(OP_TICK, 0, '1, '1);
      settle_pool();

      // random phases, each under its own tick rate and sender idling
      for (int p = 0; p < PHASES; p++) begin
         write_tick_rate(RATE_W'(phase_rate[p]));
         sender_idle_pct = phase_idle[p];
         @(negedge clock);
         for (int n = 0; n < phase_items[p]; n++) begin
            pending_requests.push_back(random_request());
         end
         settle_pool();
      end

      if (mismatch_count == 0) begin
         $display("keyed_oneshot_timer_pool_tb OK");
      end else begin
         $display("keyed_oneshot_timer_pool_tb NOT OK");
      end
      $finish;
   end

endmodule

@@ keyed_oneshot_timer_pool.f @@
rtl/core/kotp_pkg.sv
rtl/core/kotp_cell.sv
rtl/core/kotp_delay.sv
rtl/core/keyed_oneshot_timer_pool.sv
verif/keyed_oneshot_timer_pool_tb.sv
